@@ src/lph_pkg.sv @@
// Shared types and codes for the linear probing hash table.
`default_nettype none
package lph_pkg;

  localparam int KEY_W    = 31;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  // Operation codes.
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_SEARCH = 2'd2;

  // Status codes.
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_MISSING = 2'd2;

  // One table entry as it sits in the slot memory.
  typedef struct packed {
    logic valid;
    key_t key;
  } entry_t;

endpackage
`default_nettype wire

@@ src/lph_home.sv @@
// Home slot unit: key modulo the table size, masked or reduced four bits per cycle.
`default_nettype none
module lph_home #(
  parameter int TABLE_SIZE = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire lph_pkg::key_t                 key,
  output logic                               done,
  output logic [$clog2(TABLE_SIZE)-1:0]      home
);
  import lph_pkg::*;

  localparam int  RW      = $clog2(TABLE_SIZE);
  localparam bit  IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

  generate
    if (IS_POW2) begin : g_mask
      // A power of two reduces to the low bits of the key.
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          home <= key[RW-1:0];
        end
      end
    end else begin : g_iter
      localparam int TW     = RW + 1;
      localparam int DIGITS = 4;
      localparam int STEPS  = (KEY_W + 1) / DIGITS;

      logic [KEY_W:0]               shreg;
      logic [$clog2(STEPS)-1:0]     cnt;
      logic                         busy;
      logic [RW-1:0]                rem_next;

      // Restoring reduction of four key bits, most significant first.
      always_comb begin
        logic [TW-1:0] t;
        rem_next = home;
        for (int i = 0; i < DIGITS; i++) begin
          t = {rem_next, shreg[KEY_W - i]};
          if (t >= TW'(TABLE_SIZE)) begin
            t = t - TW'(TABLE_SIZE);
          end
          rem_next = t[RW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
          cnt  <= '0;
        end else begin
          done <= 1'b0;
          if (start) begin
            busy <= 1'b1;
            cnt  <= '0;
          end else if (busy) begin
            cnt <= cnt + 1'b1;
            if (cnt == ($clog2(STEPS))'(STEPS - 1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        end
        if (start) begin
          shreg <= {1'b0, key};
          home  <= '0;
        end else if (busy) begin
          shreg <= shreg << DIGITS;
          home  <= rem_next;
        end
      end
    end
  endgenerate

endmodule
`default_nettype wire

@@ src/linear_probe_hash_table_core.sv @@
// Linear probing hash table: request sequencer around a single slot memory.
// Steps: accept, home slot (masked for a power-of-two table, else reduced iteratively),
//   one probe per slot visited (1 to TABLE_SIZE), then the result into the output register;
//   an unused operation code goes straight from accept to the result.
// Throughput: one item at a time, set by the probe loop through the slot memory; a new
//   request is taken only after the result is loaded, which waits on out_stall.
// Reset: synchronous; a clearing pass over every slot empties the memory, with
//   in_stall held high meanwhile.
`default_nettype none
module linear_probe_hash_table_core #(
  parameter int TABLE_SIZE = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lph_pkg::op_t       op,
  input  wire lph_pkg::key_t      key,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lph_pkg::status_t        status,
  output logic                    hit,
  output lph_pkg::slot_t          slot
);
  import lph_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HOME, S_PROBE, S_RESULT} state_t;

  state_t        state;
  op_t           req_op;
  key_t          req_key;
  logic [IW-1:0] cur_idx;
  logic [IW-1:0] cnt;
  logic [IW-1:0] nxt_idx;
  logic [XW-1:0] idx_ext;
  status_t       res_status;
  logic          res_hit;
  slot_t         res_slot;

  // Slot memory and its ports.
  entry_t        mem [TABLE_SIZE];
  entry_t        rd_q;
  entry_t        wr_data;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          wr_en;

  logic          home_start;
  logic          home_done;
  logic [IW-1:0] home_idx;
  logic          found;
  logic          out_free;

  lph_home #(.TABLE_SIZE(TABLE_SIZE)) u_home (
    .clk   (clk),
    .rst   (rst),
    .start (home_start),
    .key   (key),
    .done  (home_done),
    .home  (home_idx)
  );

  assign in_stall   = (state != S_IDLE);
  assign home_start = (state == S_IDLE) && in_valid &&
                      ((op == OP_INSERT) || (op == OP_DELETE) || (op == OP_SEARCH));
  assign nxt_idx    = (cur_idx == LAST) ? '0 : cur_idx + 1'b1;
  assign idx_ext    = XW'(cur_idx);
  assign out_free   = !out_valid || !out_stall;

  // Probe condition on the entry just read.
  always_comb begin
    if (req_op == OP_INSERT) begin
      found = !rd_q.valid;
    end else begin
      found = rd_q.valid && (rd_q.key == req_key);
    end
  end

  // Memory address and write selection.
  always_comb begin
    rd_addr = cur_idx;
    wr_addr = cur_idx;
    wr_en   = 1'b0;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_HOME: begin
        rd_addr = home_idx;
      end
      S_PROBE: begin
        if (found) begin
          wr_en   = (req_op == OP_INSERT) || (req_op == OP_DELETE);
          wr_data = '{valid: (req_op == OP_INSERT), key: req_key};
        end else begin
          rd_addr = nxt_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // Slot memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Request sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cur_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          cur_idx <= nxt_idx;
          if (cur_idx == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_op     <= op;
            req_key    <= key;
            res_status <= ST_MISSING;
            res_hit    <= 1'b0;
            res_slot   <= '0;
            state      <= home_start ? S_HOME : S_RESULT;
          end
        end
        S_HOME: begin
          if (home_done) begin
            cur_idx <= home_idx;
            cnt     <= '0;
            state   <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (found) begin
            res_status <= ST_OK;
            res_hit    <= (req_op != OP_INSERT);
            res_slot   <= idx_ext[SLOT_W-1:0];
            state      <= S_RESULT;
          end else if (cnt == LAST) begin
            res_status <= (req_op == OP_INSERT) ? ST_FULL : ST_MISSING;
            state      <= S_RESULT;
          end else begin
            cur_idx <= nxt_idx;
            cnt     <= cnt + 1'b1;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= res_status;
            hit       <= res_hit;
            slot      <= res_slot;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A reported hit always comes with a success status.
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == ST_OK)
    else $error("hit reported without success status");

  // A failed request reports slot zero and no hit.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (slot == '0) && !hit)
    else $error("failed request carries slot or hit");

  // The memory is written only while clearing or at the end of a probe.
  a_write_when: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR) || (state == S_PROBE))
    else $error("slot memory written outside clear or probe");

  // A new result comes only out of the result state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RESULT)
    else $error("result loaded from wrong state");

endmodule
`default_nettype wire

@@ dv/linear_probe_hash_table_checker.sv @@
// Checker for the linear probing hash table: slot table predictor and result comparison.
`timescale 1ns / 100ps
module linear_probe_hash_table_checker #(
  parameter int TABLE_SIZE = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  lph_pkg::op_t     op,
  input  lph_pkg::key_t    key,
  input  logic             out_valid,
  input  logic             out_stall,
  input  lph_pkg::status_t status,
  input  logic             hit,
  input  lph_pkg::slot_t   slot,
  output int               pending,
  output int               fails
);
  import lph_pkg::*;

  typedef struct packed {
    status_t status;
    logic    hit;
    slot_t   slot;
  } reply_t;

  // Predicted copy of the slot memory.
  key_t   stored_key [TABLE_SIZE];
  logic   slot_used  [TABLE_SIZE];
  reply_t expected_replies[$];
  int     results_seen = 0;

  initial begin
    pending = 0;
    fails   = 0;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t ns: result %0d, %s mismatch: got %0d, expected %0d",
             $time, results_seen, field, got, want);
    fails++;
  endtask

  // Applies one request to the predicted table and returns the result it should give.
  function automatic reply_t serve_request(input op_t req_op, input key_t req_key);
    reply_t r;
    int     idx;
    int     found;
    int     n;
    r.status = ST_MISSING;
    r.hit    = 1'b0;
    r.slot   = '0;
    found    = -1;
    idx      = int'({1'b0, req_key} % TABLE_SIZE);
    case (req_op)
      OP_INSERT: begin
        // First empty slot from home, wrapping around.
        for (n = 0; n < TABLE_SIZE && found < 0; n++) begin
          if (!slot_used[idx]) found = idx;
          else idx = (idx + 1) % TABLE_SIZE;
        end
        if (found < 0) begin
          r.status = ST_FULL;
        end else begin
          stored_key[found] = req_key;
          slot_used[found]  = 1'b1;
          r.status          = ST_OK;
          r.slot            = slot_t'(found);
        end
      end
      OP_DELETE, OP_SEARCH: begin
        // First occupied slot holding the key, probing every slot from home.
        for (n = 0; n < TABLE_SIZE && found < 0; n++) begin
          if (slot_used[idx] && stored_key[idx] == req_key) found = idx;
          else idx = (idx + 1) % TABLE_SIZE;
        end
        if (found >= 0) begin
          if (req_op == OP_DELETE) slot_used[found] = 1'b0;
          r.status = ST_OK;
          r.hit    = 1'b1;
          r.slot   = slot_t'(found);
        end
      end
      default: begin
        // Unused operation code: nothing changes, reported as not found.
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_used[i]  = 1'b0;
        stored_key[i] = '0;
      end
      expected_replies.delete();
    end else begin
      // Compare an accepted result with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unrequested result, status", int'(status), -1);
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status) report_mismatch("status", int'(status), int'(want.status));
          if (hit !== want.hit) report_mismatch("hit", int'(hit), int'(want.hit));
          if (slot !== want.slot) report_mismatch("slot", int'(slot), int'(want.slot));
        end
        results_seen++;
      end
      // Predict the result of an accepted request.
      if (in_valid && !in_stall) expected_replies.push_back(serve_request(op, key));
    end
    pending <= expected_replies.size();
  end

endmodule

@@ dv/tb_linear_probe_hash_table_core.sv @@
// Testbench top for the linear probing hash table: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_linear_probe_hash_table_core;
  import lph_pkg::*;

  localparam int  TABLE_SIZE     = 8;
  localparam int  ITEM_COUNT     = 1750;
  localparam int  STALL_PCT      = 31;
  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  POOL_SIZE      = 10;
  localparam op_t OP_UNUSED      = 2'd3;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    in_valid  = 1'b0;
  op_t     op        = OP_INSERT;
  key_t    key       = '0;
  logic    out_stall = 1'b0;
  logic    in_stall;
  logic    out_valid;
  status_t status;
  logic    hit;
  slot_t   slot;
  int      pending;
  int      fails;
  logic    calm         = 1'b0;
  int      quiet_cycles = 0;
  key_t    key_pool [POOL_SIZE];

  linear_probe_hash_table_core #(.TABLE_SIZE(TABLE_SIZE)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .key(key),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .hit(hit), .slot(slot)
  );

  linear_probe_hash_table_checker #(.TABLE_SIZE(TABLE_SIZE)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .key(key),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .hit(hit), .slot(slot),
    .pending(pending), .fails(fails)
  );

  always #2 clk = ~clk;

  // Random back pressure on results, switched off during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one request, with random idle cycles ahead of it, and waits until it is taken.
  task automatic send_item(input op_t req_op, input key_t req_key);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= req_op;
    key      <= req_key;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int   sent;
    int   burst;
    int   ins_pct;
    int   roll;
    op_t  pick_op;
    key_t pick_key;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes, collisions, wrap, duplicates, misses, full table.
    send_item(OP_INSERT, 31'd0);
    send_item(OP_INSERT, 31'h7FFF_FFFF);
    send_item(OP_INSERT, 31'd8);
    send_item(OP_INSERT, 31'd0);
    send_item(OP_INSERT, 31'd15);
    send_item(OP_SEARCH, 31'd0);
    send_item(OP_DELETE, 31'd0);
    send_item(OP_SEARCH, 31'd0);
    send_item(OP_SEARCH, 31'd16);
    send_item(OP_DELETE, 31'd24);
    send_item(OP_UNUSED, 31'd8);
    send_item(OP_SEARCH, 31'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) begin
      send_item(OP_INSERT, (i % 2 == 0) ? 31'h2AAA_AAAA + key_t'(i) : 31'h5555_5555 ^ key_t'(i));
    end
    send_item(OP_SEARCH, 31'h1234_5678);
    send_item(OP_DELETE, 31'd8);
    send_item(OP_DELETE, 31'd15);
    send_item(OP_SEARCH, 31'h7FFF_FFFF);
    send_item(OP_INSERT, 31'h4000_0000);

    // Random part: bursts with a varying mix, keys mostly from a small pool.
    sent  = 0;
    burst = 0;
    while (sent < ITEM_COUNT) begin
      if (burst % 4 == 0) begin
        // Fresh pool; a few keys share the home slot of the first one.
        for (int i = 0; i < POOL_SIZE; i++) begin
          if (i >= 4 && i < 8) key_pool[i] = key_pool[0] + key_t'(i * TABLE_SIZE);
          else key_pool[i] = key_t'($urandom);
        end
      end
      case ($urandom_range(3))
        0: ins_pct = 15;
        1: ins_pct = 45;
        2: ins_pct = 65;
        default: ins_pct = 90;
      endcase
      repeat (40) begin
        roll = $urandom_range(99);
        if (roll < 3) pick_op = OP_UNUSED;
        else if ($urandom_range(99) < ins_pct) pick_op = OP_INSERT;
        else if ($urandom_range(1) == 1) pick_op = OP_DELETE;
        else pick_op = OP_SEARCH;
        roll = $urandom_range(99);
        if (roll < 80) pick_key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else if (roll < 95) pick_key = key_t'($urandom);
        else pick_key = ($urandom_range(1) == 1) ? '1 : '0;
        calm = (sent >= 700 && sent < 1000);
        send_item(pick_op, pick_key);
        sent++;
      end
      burst++;
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then keep waiting for stray results before the verdict.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * TABLE_SIZE + 8) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lph_pkg.sv
src/lph_home.sv
src/linear_probe_hash_table_core.sv
dv/linear_probe_hash_table_checker.sv
dv/tb_linear_probe_hash_table_core.sv
